// ----- hdl/pbec_pkg.sv -----
// ---------------------------------------------------------------------------
// pbec_pkg - shared types for the push-button event classifier
// Register indexes, widths and the event record passed between modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbec_pkg;

  localparam int unsigned DelayWidth   = 8;
  localparam int unsigned CounterWidth = 9;
  localparam int unsigned CfgIdxWidth  = 1;

  localparam logic [CounterWidth-1:0] CounterMax = '1;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_ACTIVE_HIGH = 1'b0,
    REG_HOLD_DELAY  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic single_pulse;
    logic double_pulse;
    logic held;
    logic held_start;
    logic held_end;
  } event_t;

endpackage : pbec_pkg

`default_nettype wire

// ----- hdl/pbec_classify.sv -----
// ---------------------------------------------------------------------------
// pbec_classify - press classification state and per-tick update
// Holds the configuration and button state; one tick is processed per step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbec_classify
  import pbec_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CfgIdxWidth-1:0] cfg_index,
  input  wire logic [DelayWidth-1:0]  cfg_data,
  input  wire logic                   step,
  input  wire logic                   level,
  output event_t                      result
);

  logic                    active_high;
  logic [DelayWidth-1:0]   hold_delay;
  logic                    last_level;
  logic                    hold_flag;
  logic [CounterWidth-1:0] hold_counter;
  logic [DelayWidth-1:0]   double_window;

  logic                    hold_flag_next;
  logic [CounterWidth-1:0] hold_counter_next;
  logic [DelayWidth-1:0]   double_window_next;
  logic [DelayWidth-1:0]   window_loaded;
  logic [CounterWidth-1:0] counter_inc;
  logic                    release_edge;
  logic                    level_write;

  // edge to the inactive level
  assign release_edge = (level != last_level) && (level != active_high);

  // active level write also resets the level register
  assign level_write = cfg_write && (cfg_reg_t'(cfg_index) == REG_ACTIVE_HIGH);

  always_comb begin
    result              = '0;
    result.single_pulse = release_edge && !hold_flag && (double_window == '0);
    result.double_pulse = release_edge && !hold_flag && (double_window != '0);
    result.held_end     = release_edge && hold_flag;

    window_loaded = result.single_pulse ? hold_delay : double_window;

    counter_inc       = (hold_counter < CounterMax) ? hold_counter + 1'b1 : hold_counter;
    hold_flag_next    = hold_flag;
    hold_counter_next = hold_counter;
    if (level == active_high) begin
      if (!hold_flag) begin
        hold_counter_next = counter_inc;
        if (counter_inc > {1'b0, hold_delay}) begin
          hold_flag_next    = 1'b1;
          result.held_start = 1'b1;
        end
      end
    end else begin
      hold_flag_next    = 1'b0;
      hold_counter_next = '0;
    end
    result.held = hold_flag_next;

    double_window_next = (window_loaded != '0) ? window_loaded - 1'b1 : window_loaded;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_high   <= 1'b1;
      hold_delay    <= DelayWidth'(10);
      last_level    <= 1'b0;
      hold_flag     <= 1'b0;
      hold_counter  <= '0;
      double_window <= '0;
    end else begin
      if (step) begin
        if (!level_write) begin
          last_level <= level;
        end
        hold_flag     <= hold_flag_next;
        hold_counter  <= hold_counter_next;
        double_window <= double_window_next;
      end
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ACTIVE_HIGH: begin
            active_high <= cfg_data[0];
            last_level  <= ~cfg_data[0];
          end
          REG_HOLD_DELAY: begin
            hold_delay <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // a release yields exactly one of the three release events
  a_release_one: assert property (@(posedge clk) disable iff (rst)
    step |-> $countones({result.single_pulse, result.double_pulse, result.held_end}) <= 1)
    else $error("more than one release event in one tick");

  // start of a hold leaves the held flag set afterwards
  a_start_held: assert property (@(posedge clk) disable iff (rst)
    (step && result.held_start && !cfg_write) |=> hold_flag)
    else $error("held_start without held flag");

  // a hold end drops the held flag
  a_end_clear: assert property (@(posedge clk) disable iff (rst)
    (step && result.held_end) |-> !result.held)
    else $error("held_end with held still set");

  // while held the counter does not move
  a_hold_counter: assert property (@(posedge clk) disable iff (rst)
    (step && hold_flag && level == active_high && !cfg_write) |=> $stable(hold_counter))
    else $error("hold counter moved during a hold");

endmodule : pbec_classify

`default_nettype wire

// ----- hdl/push_button_event_classifier.sv -----
// ---------------------------------------------------------------------------
// push_button_event_classifier - click / double click / long press detector
// Classifies one sampled switch level per tick into button events.
// ---------------------------------------------------------------------------
// Usage:
//   Sample channel: one request per tick carries sampled_level, under
//   sample_valid / sample_stall. Event channel: one request per accepted
//   tick carries single_pulse, double_pulse, held, held_start and held_end
//   under event_valid / event_stall.
//   Configuration: cfg_write with cfg_index selects active_high (0) or
//   hold_delay (1); cfg_data carries the value. Write only while idle.
//   Path: the sample lands in the input register, then the classification step
//   loads the result register, which drives event_valid.
//   Throughput: one request per cycle while event_stall is low, set by the
//   state update between the two registers.
//   Stall: while event_stall holds a full result register, the input register
//   keeps its sample and sample_stall rises once both are occupied; nothing
//   is dropped and a stalled event holds its value.
//   Reset (rst, synchronous): active high pressed, hold_delay 10, state idle
//   with the level register at the inactive level; both registers empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module push_button_event_classifier
  import pbec_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CfgIdxWidth-1:0] cfg_index,
  input  wire logic [DelayWidth-1:0]  cfg_data,
  input  wire logic                   sample_valid,
  output logic                        sample_stall,
  input  wire logic                   sampled_level,
  output logic                        event_valid,
  input  wire logic                   event_stall,
  output logic                        single_pulse,
  output logic                        double_pulse,
  output logic                        held,
  output logic                        held_start,
  output logic                        held_end
);

  // input register
  logic   sample_full;
  logic   sample_level;
  // result register
  logic   result_full;
  event_t result;

  event_t step_result;
  logic   result_free;
  logic   step;
  logic   take_sample;

  // result register can load when empty or being drained this cycle
  assign result_free  = !result_full || !event_stall;
  assign step         = sample_full && result_free;
  assign sample_stall = sample_full && !result_free;
  assign take_sample  = sample_valid && !sample_stall;

  pbec_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .level     (sample_level),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_full <= 1'b0;
      result_full <= 1'b0;
    end else begin
      if (take_sample) begin
        sample_full <= 1'b1;
      end else if (step) begin
        sample_full <= 1'b0;
      end
      if (step) begin
        result_full <= 1'b1;
      end else if (!event_stall) begin
        result_full <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (take_sample) begin
      sample_level <= sampled_level;
    end
    if (step) begin
      result <= step_result;
    end
  end

  assign event_valid  = result_full;
  assign single_pulse = result.single_pulse;
  assign double_pulse = result.double_pulse;
  assign held         = result.held;
  assign held_start   = result.held_start;
  assign held_end     = result.held_end;

  // a full input register moves on whenever the result side is free
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    (sample_full && !event_stall) |=> result_full)
    else $error("sample not forwarded to result register");

  // stall only when both registers are occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (sample_full && result_full))
    else $error("input stalled with space available");

  // a stalled result does not change
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (event_valid && event_stall) |=> (event_valid && $stable(result)))
    else $error("stalled result changed");

endmodule : push_button_event_classifier

`default_nettype wire

// ----- test/tb.sv -----
// ---------------------------------------------------------------------------
// tb - self-checking bench for the push-button event classifier
// Drives sampled switch levels as sample requests and checks every event
// request, field by field, against a behavioural classifier kept in the
// bench. A short table of directed ticks and register writes comes first.
// After it, phases of random press and release runs follow, each phase under
// its own active level and hold delay. Both channels idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pbec_pkg::*;

  // Clock, reset and block inputs. All of them start at known values.
  logic                    clk           = 1'b0;
  logic                    rst           = 1'b1;
  logic                    cfg_write     = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_index     = '0;
  logic [DelayWidth-1:0]   cfg_data      = '0;
  logic                    sample_valid  = 1'b0;
  logic                    sampled_level = 1'b0;
  logic                    event_stall   = 1'b0;

  logic sample_stall;
  logic event_valid;
  logic single_pulse;
  logic double_pulse;
  logic held;
  logic held_start;
  logic held_end;

  push_button_event_classifier uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sampled_level(sampled_level),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .single_pulse (single_pulse),
    .double_pulse (double_pulse),
    .held         (held),
    .held_start   (held_start),
    .held_end     (held_end)
  );

  // 2 ns period
  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop. A correct run finishes well before this limit, even under the
  // heaviest stall mix.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Behavioural classifier: own copy of the registers and the tick state.
  // -------------------------------------------------------------------------
  logic                    cls_active_high = 1'b1;
  logic [DelayWidth-1:0]   cls_hold_delay  = 8'd10;
  logic                    cls_last_level  = 1'b0;
  logic                    cls_hold_flag   = 1'b0;
  logic [CounterWidth-1:0] cls_hold_count  = '0;
  logic [DelayWidth-1:0]   cls_dbl_window  = '0;

  // One tick: edge handling, then level, then window countdown.
  function automatic event_t classify_tick(logic lvl);
    event_t ev;
    ev = '0;
    if (lvl != cls_last_level) begin
      // a release only matters on the edge to the inactive level
      if (lvl != cls_active_high) begin
        if (cls_hold_flag) begin
          ev.held_end = 1'b1;
        end else if (cls_dbl_window != '0) begin
          ev.double_pulse = 1'b1;
        end else begin
          ev.single_pulse = 1'b1;
          cls_dbl_window  = cls_hold_delay;
        end
      end
      cls_last_level = lvl;
    end
    if (cls_last_level == cls_active_high) begin
      if (!cls_hold_flag) begin
        if (cls_hold_count != CounterMax) cls_hold_count = cls_hold_count + 1'b1;
        if (cls_hold_count > {1'b0, cls_hold_delay}) begin
          cls_hold_flag = 1'b1;
          ev.held_start = 1'b1;
        end
      end
    end else begin
      cls_hold_flag  = 1'b0;
      cls_hold_count = '0;
    end
    // counts down on the loading tick too
    if (cls_dbl_window != '0) cls_dbl_window = cls_dbl_window - 1'b1;
    ev.held = cls_hold_flag;
    return ev;
  endfunction

  // Events still owed by the block, oldest first.
  event_t owed_events[$];
  int     fails = 0;

  // -------------------------------------------------------------------------
  // Event monitor: a request completes on a rising edge with valid high and
  // stall low. Outputs are read before the edge's updates land.
  // -------------------------------------------------------------------------
  task automatic check_field(string name, logic want, logic got);
    if (want !== got) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    event_t want;
    if (!rst && event_valid && !event_stall) begin
      if (owed_events.size() == 0) begin
        $error("event request with none owed");
        fails++;
      end else begin
        want = owed_events.pop_front();
        check_field("single_pulse", want.single_pulse, single_pulse);
        check_field("double_pulse", want.double_pulse, double_pulse);
        check_field("held",         want.held,         held);
        check_field("held_start",   want.held_start,   held_start);
        check_field("held_end",     want.held_end,     held_end);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Event side back-pressure: a pattern that changes mode every so often,
  // including stretches with no stall at all.
  // -------------------------------------------------------------------------
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  initial begin
    stall_mode_t stall_mode;
    int          stall_left;
    stall_mode = STALL_NONE;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(16, 128);
      end
      stall_left--;
      case (stall_mode)
        STALL_NONE:  event_stall <= 1'b0;
        STALL_LIGHT: event_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: event_stall <= ($urandom_range(0, 3) != 0);
        default:     event_stall <= ((stall_left % 8) < 3);
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Sample side. Requests go out in bursts of random length; between bursts
  // valid drops for a random gap (sometimes none).
  // -------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_tick(logic lvl, logic typed, event_t typed_ev);
    int     gap;
    event_t ev;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        sample_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    sample_valid  <= 1'b1;
    sampled_level <= lvl;
    // payload holds until the request is taken
    do @(posedge clk); while (sample_stall);
    burst_left--;
    ev = classify_tick(lvl);
    owed_events.push_back(typed ? typed_ev : ev);
  endtask

  // Stop sending and wait for every owed event. Each tick gives exactly one
  // event, so once the queue is empty the block has nothing in flight.
  task automatic await_quiet();
    @(negedge clk);
    sample_valid <= 1'b0;
    burst_left = 0;
    while (owed_events.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [DelayWidth-1:0] val);
    await_quiet();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_ACTIVE_HIGH) begin
      cls_active_high = val[0];
      cls_last_level  = ~val[0];   // level register drops to the new inactive level
    end else begin
      cls_hold_delay = val;
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Directed table. Events are typed in only where obvious; other rows are
  // left to the classifier. Event bits: single, double, held, start, end.
  // -------------------------------------------------------------------------
  typedef enum int {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    cfg_reg_t              idx;
    logic [DelayWidth-1:0] val;
    logic                  lvl;
    logic                  typed;
    event_t                want;
  } row_t;

  row_t directed [23] = '{
    // reset state: idle, a press, a short release, then a quick second click
    '{ROW_TICK,  REG_ACTIVE_HIGH, 8'd0,   1'b0, 1'b1, 5'b00000},
    '{ROW_TICK,  REG_ACTIVE_HIGH, 8'd0,   1'b1, 1'b1, 5'b00000},
    '{ROW_TICK,  REG_ACTIVE_HIGH, 8'd0,   1'b0, 1'b1, 5'b10000},
    '{ROW_TICK,  REG_ACTIVE_HIGH, 8'd0,   1'b1, 1'b0, 5'b00000},
    '{ROW_TICK,  REG_ACTIVE_HIGH, 8'd0,   1'b0, 1'b1, 5'b01000},
    // zero delay: long hold on the first pressed tick, then held end
    '{ROW_WRITE, REG_HOLD_DELAY,  8'd0,   1'b0, 1'b0, 5'b00000},
    '{ROW_TICK,  REG_ACTIVE_HIGH, 8'd0,   1'b1, 1'b1, 5'b00110},
    '{ROW_TICK,  REG_ACTIVE_HIGH, 8'd0,   1'b1, 1'b0, 5'b00000},
    '{ROW_TICK,  REG_ACTIVE_HIGH, 8'd0,   1'b0, 1'b1, 5'b00001},
    // widest delay, short click
    '{ROW_WRITE, REG_HOLD_DELAY,  8'd255, 1'b0, 1'b0, 5'b00000},
    '{ROW_TICK,  REG_ACTIVE_HIGH, 8'd0,   1'b1, 1'b0, 5'b00000},
    '{ROW_TICK,  REG_ACTIVE_HIGH, 8'd0,   1'b0, 1'b0, 5'b00000},
    // active low, upper data bits set and ignored
    '{ROW_WRITE, REG_ACTIVE_HIGH, 8'hFE,  1'b0, 1'b0, 5'b00000},
    '{ROW_TICK,  REG_ACTIVE_HIGH, 8'd0,   1'b1, 1'b0, 5'b00000},
    '{ROW_TICK,  REG_ACTIVE_HIGH, 8'd0,   1'b0, 1'b0, 5'b00000},
    '{ROW_TICK,  REG_ACTIVE_HIGH, 8'd0,   1'b1, 1'b0, 5'b00000},
    // delay of one, low-level hold then release
    '{ROW_WRITE, REG_HOLD_DELAY,  8'd1,   1'b0, 1'b0, 5'b00000},
    '{ROW_TICK,  REG_ACTIVE_HIGH, 8'd0,   1'b0, 1'b0, 5'b00000},
    '{ROW_TICK,  REG_ACTIVE_HIGH, 8'd0,   1'b0, 1'b0, 5'b00000},
    '{ROW_TICK,  REG_ACTIVE_HIGH, 8'd0,   1'b0, 1'b0, 5'b00000},
    '{ROW_TICK,  REG_ACTIVE_HIGH, 8'd0,   1'b1, 1'b0, 5'b00000},
    // back to reset settings
    '{ROW_WRITE, REG_ACTIVE_HIGH, 8'h01,  1'b0, 1'b0, 5'b00000},
    '{ROW_WRITE, REG_HOLD_DELAY,  8'd10,  1'b0, 1'b0, 5'b00000}
  };

  // Random phases: a hold delay per phase (-1 picks a small random one);
  // the active level alternates so both polarities run.
  int phase_delay [8] = '{3, 0, 255, 1, -1, 2, -1, 10};

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    int   i;
    int   p;
    int   n;
    int   hd;
    int   target;
    int   sent;
    logic act;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < $size(directed); i++) begin
      if (directed[i].kind == ROW_WRITE) begin
        write_reg(directed[i].idx, directed[i].val);
      end else begin
        send_tick(directed[i].lvl, directed[i].typed, directed[i].want);
      end
    end

    for (p = 0; p < $size(phase_delay); p++) begin
      hd     = (phase_delay[p] < 0) ? $urandom_range(2, 15) : phase_delay[p];
      act    = p[0];
      target = (hd == 255) ? 250 : 60;
      write_reg(REG_ACTIVE_HIGH, {7'($urandom_range(0, 127)), act});
      write_reg(REG_HOLD_DELAY, 8'(hd));
      sent = 0;
      while (sent < target) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: glitchy levels with no structure
          n = $urandom_range(1, 8);
          repeat (n) send_tick(1'($urandom_range(0, 1)), 1'b0, '0);
          sent += n;
        end else begin
          // a press run, short or past the hold delay, then a release run
          // that may fall inside the double-click window
          if (hd == 255) n = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 20)
                                                         : $urandom_range(240, 300);
          else           n = $urandom_range(1, 2 * hd + 3);
          repeat (n) send_tick(act, 1'b0, '0);
          sent += n;
          n = $urandom_range(1, (hd == 255) ? 40 : hd + 3);
          repeat (n) send_tick(~act, 1'b0, '0);
          sent += n;
        end
        // now and then let the block drain completely mid-phase
        if ($urandom_range(0, 24) == 0) await_quiet();
      end
    end

    await_quiet();
    repeat (8) @(posedge clk);
    if (fails == 0 && owed_events.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
